// File: rtl/core/bitmap_block_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// shared property wrappers for the allocator core
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define BBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// widths, command codes and shared types of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_BYTES_DEF = 512;
    localparam int CMD_W         = 2;
    localparam int IDX_W         = 9;
    localparam int BYTE_W        = 8;
    localparam int BIT_W         = 3;
    localparam int BLK_W         = 12;
    localparam int DATA_W        = 24;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  bit_idx;
        logic [BYTE_W-1:0] set_byte;
    } pick_t;

endpackage

// File: rtl/core/bba_bit_pick.sv
// ----------------------------------------------------------------------------
// bba_bit_pick
// finds the lowest clear bit of a bitmap byte and the byte with it set
// ----------------------------------------------------------------------------
module bba_bit_pick
    import bba_pkg::*;
(
    input  logic [BYTE_W-1:0] byte_in,
    output pick_t             pick
);

    always_comb
    begin
        pick.found    = 1'b0;
        pick.bit_idx  = '0;
        pick.set_byte = byte_in;
        // walk down so the lowest clear bit wins
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (!byte_in[i])
            begin
                pick.found   = 1'b1;
                pick.bit_idx = BIT_W'(i);
            end
        end
        if (pick.found)
        begin
            pick.set_byte = byte_in | (BYTE_W'(1) << pick.bit_idx);
        end
    end

endmodule

// File: rtl/core/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// first-fit free-block bitmap with byte write, byte read and allocate
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata, low bit first)
// s_*      in   command[1:0] byte_index[10:2] byte_value[18:11]
// m_*      out  block_number[11:0] map_full[12] read_byte[20:13]
//
// one beat in flight: s_tready is high only while idle
// allocate scans from byte 0 to the first byte not full and sets map_full
// when every byte is full; the single ram read port bounds the scan
// after reset a clearing pass zeroes the bitmap
// a new beat is taken while the previous result still waits in m_tdata
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_core_defines.svh"

module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // command, byte_index, byte_value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata    // block_number, map_full, read_byte
);

    localparam int AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNTW   = $clog2(MAP_BYTES + 1);
    localparam int CW     = (CNTW > IDX_W) ? CNTW : IDX_W;
    localparam int OUT_PAD = DATA_W - BLK_W - 1 - BYTE_W;
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(MAP_BYTES - 1);
    localparam logic [CNTW-1:0] END_CNT  = CNTW'(MAP_BYTES);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNTW-1:0]   issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     chk_reg, chk_next;
    logic              rd_range_reg, rd_range_next;
    logic [BLK_W-1:0]  res_block_reg, res_block_next;
    logic              res_full_reg, res_full_next;
    logic [BYTE_W-1:0] res_byte_reg, res_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    logic [BYTE_W-1:0] mem [MAP_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic [CMD_W-1:0]  in_cmd;
    logic [CW-1:0]     idx_ext;
    logic              in_range;
    logic [AW-1:0]     idx_addr;
    pick_t             pick;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign idx_ext  = CW'(s_tdata[CMD_W+IDX_W-1:CMD_W]);
    assign in_range = idx_ext < CW'(MAP_BYTES);
    assign idx_addr = idx_ext[AW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    bba_bit_pick u_pick (
        .byte_in (rd_data_reg),
        .pick    (pick)
    );

    // bitmap ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        chk_next       = chk_reg;
        rd_range_next  = rd_range_reg;
        res_block_next = res_block_reg;
        res_full_next  = res_full_reg;
        res_byte_next  = res_byte_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = issue_reg[AW-1:0];
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[AW-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (issue_reg == LAST_CNT)
                begin
                    issue_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    issue_next = CNTW'(issue_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_block_next = '0;
                    res_full_next  = 1'b0;
                    res_byte_next  = '0;
                    case (in_cmd)
                        CMD_WRITE:
                        begin
                            wr_en      = in_range;
                            wr_addr    = idx_addr;
                            wr_data    = s_tdata[CMD_W+IDX_W+BYTE_W-1:CMD_W+IDX_W];
                            state_next = ST_OUT;
                        end
                        CMD_READ:
                        begin
                            rd_en         = in_range;
                            rd_addr       = idx_addr;
                            rd_range_next = in_range;
                            state_next    = ST_READ;
                        end
                        CMD_ALLOC:
                        begin
                            issue_next = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_byte_next = rd_range_reg ? rd_data_reg : '0;
                state_next    = ST_OUT;
            end
            ST_SCAN:
            begin
                // rd_data_reg holds byte chk_reg while pend_reg is set
                if (pend_reg && pick.found)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = chk_reg;
                    wr_data        = pick.set_byte;
                    res_block_next = BLK_W'({chk_reg, pick.bit_idx});
                    pend_next      = 1'b0;
                    state_next     = ST_OUT;
                end
                else if (pend_reg && (issue_reg == END_CNT))
                begin
                    res_full_next = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = ST_OUT;
                end
                else if (issue_reg != END_CNT)
                begin
                    rd_en      = 1'b1;
                    chk_next   = issue_reg[AW-1:0];
                    issue_next = CNTW'(issue_reg + 1'b1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD{1'b0}}, res_byte_reg, res_full_reg,
                                      res_block_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg       <= chk_next;
        rd_range_reg  <= rd_range_next;
        res_block_reg <= res_block_next;
        res_full_reg  <= res_full_next;
        res_byte_reg  <= res_byte_next;
        out_data_reg  <= out_data_next;
    end

    `BBA_ASSERT_SAME(a_full_fields_zero, clk, rst_n, m_tvalid && m_tdata[BLK_W], (m_tdata[BLK_W-1:0] == '0) && (m_tdata[BLK_W+BYTE_W:BLK_W+1] == '0))
    `BBA_ASSERT_NEXT(a_one_beat_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `BBA_ASSERT_SAME(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, issue_reg <= END_CNT)
    `BBA_ASSERT_SAME(a_hit_writes_back, clk, rst_n, (state_reg == ST_SCAN) && pend_reg && pick.found, wr_en && (wr_addr == chk_reg))

endmodule
